// ----- hdl/cdt_pkg.sv -----
// Package for the countdown timer with LED bar and buzzer.
// Holds shared constants, register indexes, types and the bar pattern function.
// No dependencies.
`default_nettype none

package cdt_pkg;

    localparam int unsigned RemainW = 20;
    localparam int unsigned HoldW   = 9;

    localparam logic [5:0]         PHASE_LAST   = 6'd49;
    localparam logic [5:0]         LED_ON_LAST  = 6'd10;
    localparam logic [5:0]         BUZZ_ON_LAST = 6'd25;
    localparam logic [HoldW-1:0]   HOLD_MAX     = 9'd511;
    localparam logic [RemainW-1:0] REMAIN_RESET = 20'd25;

    localparam logic [9:0] HSPM_RESET       = 10'd5;
    localparam logic [7:0] DEBOUNCE_RESET   = 8'd8;
    localparam logic [7:0] LONG_PRESS_RESET = 8'd10;

    typedef enum logic [1:0] {
        CFG_HSPM       = 2'd0,
        CFG_DEBOUNCE   = 2'd1,
        CFG_LONG_PRESS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0] u1;
        logic [13:0] u2;
        logic [13:0] u3;
        logic [14:0] u4;
        logic [7:0]  debounce;
        logic [7:0]  long_press;
    } t_cfg;

    typedef struct packed {
        logic [4:0] leds;
        logic       buzzer;
        logic       active;
    } t_res;

    function automatic logic [4:0] bar_pattern(input logic [RemainW-1:0] cnt,
                                               input t_cfg c);
        logic [4:0] pat;
        begin
            if (cnt <= RemainW'(c.u1)) begin
                pat = 5'h01;
            end else if (cnt <= RemainW'(c.u2)) begin
                pat = 5'h03;
            end else if (cnt <= RemainW'(c.u3)) begin
                pat = 5'h07;
            end else if (cnt <= RemainW'(c.u4)) begin
                pat = 5'h0F;
            end else begin
                pat = 5'h1F;
            end
            return pat;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cdt_in_if.sv -----
// Request channel interface: one event per request.
// Depends on nothing.
`default_nettype none

interface cdt_in_if;
    logic valid;
    logic ready;
    logic func;
    logic button_level;

    modport source (output valid, output func, output button_level, input ready);
    modport sink   (input valid, input func, input button_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/cdt_out_if.sv -----
// Result channel interface: LED bar, buzzer and active flag per request.
// Depends on nothing.
`default_nettype none

interface cdt_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] leds;
    logic       buzzer;
    logic       active;

    modport source (output valid, output leds, output buzzer, output active, input ready);
    modport sink   (input valid, input leds, input buzzer, input active, output ready);
endinterface

`default_nettype wire

// ----- hdl/cdt_cfg.sv -----
// Configuration registers with precomputed bar thresholds.
// Depends on cdt_pkg.
`default_nettype none

module cdt_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [9:0]    i_cfg_wdata,
    output cdt_pkg::t_cfg      o_cfg
);

    logic [12:0] r_u1;
    logic [13:0] r_u3;
    logic [7:0]  r_debounce;
    logic [7:0]  r_long_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1         <= 13'(cdt_pkg::HSPM_RESET) * 13'd5;
            r_u3         <= 14'(cdt_pkg::HSPM_RESET) * 14'd15;
            r_debounce   <= cdt_pkg::DEBOUNCE_RESET;
            r_long_press <= cdt_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cdt_pkg::CFG_HSPM: begin
                    r_u1 <= {1'b0, i_cfg_wdata, 2'b00} + 13'(i_cfg_wdata);
                    r_u3 <= {i_cfg_wdata, 4'b0000} - 14'(i_cfg_wdata);
                end
                cdt_pkg::CFG_DEBOUNCE: begin
                    r_debounce <= i_cfg_wdata[7:0];
                end
                cdt_pkg::CFG_LONG_PRESS: begin
                    r_long_press <= i_cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.u1         = r_u1;
    assign o_cfg.u2         = {r_u1, 1'b0};
    assign o_cfg.u3         = r_u3;
    assign o_cfg.u4         = {r_u1, 2'b00};
    assign o_cfg.debounce   = r_debounce;
    assign o_cfg.long_press = r_long_press;

endmodule

`default_nettype wire

// ----- hdl/cdt_core.sv -----
// Timer state and the per-event update of counters, LED bar and buzzer.
// Depends on cdt_pkg.
`default_nettype none

module cdt_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_func,
    input  wire logic          i_level,
    input  wire cdt_pkg::t_cfg i_cfg,
    output cdt_pkg::t_res      o_res
);

    logic                        r_active;
    logic [cdt_pkg::RemainW-1:0] r_remain;
    logic [5:0]                  r_phase;
    logic [7:0]                  r_debounce;
    logic [cdt_pkg::HoldW-1:0]   r_hold;
    logic [4:0]                  r_leds;
    logic                        r_buzzer;

    logic                        n_active;
    logic [cdt_pkg::RemainW-1:0] n_remain;
    logic [5:0]                  n_phase;
    logic [7:0]                  n_debounce;
    logic [cdt_pkg::HoldW-1:0]   n_hold;
    logic [4:0]                  n_leds;
    logic                        n_buzzer;

    logic [cdt_pkg::RemainW:0]   sum;
    logic [cdt_pkg::RemainW-1:0] sat;
    logic [cdt_pkg::RemainW-1:0] bar_cnt;
    logic [4:0]                  bar;

    always_comb begin
        sum     = {1'b0, r_remain} + (cdt_pkg::RemainW + 1)'(i_cfg.u1);
        sat     = sum[cdt_pkg::RemainW] ? '1 : sum[cdt_pkg::RemainW-1:0];
        bar_cnt = i_func ? sat : r_remain;
        bar     = cdt_pkg::bar_pattern(bar_cnt, i_cfg);

        n_active   = r_active;
        n_remain   = r_remain;
        n_phase    = r_phase;
        n_debounce = r_debounce;
        n_hold     = r_hold;
        n_leds     = r_leds;
        n_buzzer   = r_buzzer;

        if (i_func) begin
            if (r_debounce == 8'd0) begin
                n_debounce = i_cfg.debounce;
                n_active   = 1'b1;
                n_buzzer   = 1'b1;
                n_remain   = sat;
                n_leds     = r_leds | bar;
            end
        end else begin
            if (r_debounce != 8'd0) begin
                n_debounce = r_debounce - 8'd1;
            end
            if (r_active) begin
                n_phase = (r_phase == cdt_pkg::PHASE_LAST) ? 6'd0 : r_phase + 6'd1;
                if (r_remain != '0) begin
                    n_buzzer = 1'b0;
                    n_leds   = (n_phase <= cdt_pkg::LED_ON_LAST) ? (r_leds | bar) : 5'd0;
                    if (n_phase == 6'd0) begin
                        n_remain = r_remain - cdt_pkg::RemainW'(1);
                    end
                end else begin
                    n_leds   = 5'd0;
                    n_buzzer = (n_phase <= cdt_pkg::BUZZ_ON_LAST);
                end
            end
            if (i_level) begin
                if (r_hold != cdt_pkg::HOLD_MAX) begin
                    n_hold = r_hold + cdt_pkg::HoldW'(1);
                end
                n_buzzer = 1'b1;
                if (n_hold == cdt_pkg::HoldW'(i_cfg.long_press)) begin
                    n_active = 1'b0;
                    n_leds   = 5'd0;
                    n_buzzer = 1'b0;
                end
            end else begin
                n_hold = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_remain   <= cdt_pkg::REMAIN_RESET;
            r_phase    <= 6'd0;
            r_debounce <= 8'd0;
            r_hold     <= '0;
            r_leds     <= 5'd0;
            r_buzzer   <= 1'b0;
        end else if (i_step) begin
            r_active   <= n_active;
            r_remain   <= n_remain;
            r_phase    <= n_phase;
            r_debounce <= n_debounce;
            r_hold     <= n_hold;
            r_leds     <= n_leds;
            r_buzzer   <= n_buzzer;
        end
    end

    assign o_res.leds   = n_leds;
    assign o_res.buzzer = n_buzzer;
    assign o_res.active = n_active;

    a_sleep_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_leds == 5'd0)
        else $error("LED bar lit while asleep");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= cdt_pkg::PHASE_LAST)
        else $error("phase counter out of range");

    a_press_wakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_func && r_debounce == 8'd0 |=> r_active && r_buzzer)
        else $error("accepted press did not activate the timer");

    a_debounce_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_func && r_debounce != 8'd0 |=> $stable(r_remain))
        else $error("press inside debounce window changed the count");

endmodule

`default_nettype wire

// ----- hdl/countdown_timer_led_bar_buzzer.sv -----
// Top level of the countdown timer with LED bar and buzzer.
// Depends on cdt_pkg, cdt_in_if, cdt_out_if, cdt_cfg and cdt_core.
//
//   port        dir  kind        content
//   i_req       in   valid/ready func, button_level
//   o_res       out  valid/ready leds, buzzer, active
//   i_cfg_*     in   write only  register index and data
//
// A request enters an input register, is processed by the core once the output register
// is free or being read, and its result is then held in the output register.
// One request per cycle is sustained while the result side is ready.
// A stalled result holds the processing stage, and a request can still be taken
// while the input register is empty or draining. Reset is synchronous and clears
// all valid flags and the timer state; there is no clearing pass.
`default_nettype none

module countdown_timer_led_bar_buzzer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cdt_in_if.sink          i_req,
    cdt_out_if.source       o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [9:0] i_cfg_wdata
);

    logic          r_in_valid;
    logic          r_in_func;
    logic          r_in_level;
    logic          r_out_valid;
    cdt_pkg::t_res r_out;

    logic          advance;
    cdt_pkg::t_cfg cfg;
    cdt_pkg::t_res res;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    cdt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_func  (r_in_func),
        .i_level (r_in_level),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_func  <= i_req.func;
            r_in_level <= i_req.button_level;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.leds   = r_out.leds;
    assign o_res.buzzer = r_out.buzzer;
    assign o_res.active = r_out.active;

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result was overwritten");

    a_sleep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.active |-> r_out.leds == 5'd0)
        else $error("result shows LEDs while asleep");

    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("pending request dropped");

endmodule

`default_nettype wire

// ----- tb/sv/cdt_result_checker.sv -----
// Checker for the countdown timer: watches the request, result and register ports,
// predicts the LED bar, buzzer and active flag, and compares each result in order.
// Depends on cdt_pkg, cdt_in_if and cdt_out_if.

module cdt_result_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cdt_in_if               i_req,
    cdt_out_if              i_res,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [9:0] i_cfg_wdata,
    output int              o_waiting,
    output int              o_errors
);

    localparam int MaxPrinted = 200;

    logic [9:0]                  unit_cfg;
    logic [7:0]                  quiet_cfg;
    logic [7:0]                  sleep_cfg;

    logic                        awake_q;
    logic [cdt_pkg::RemainW-1:0] left_q;
    logic [5:0]                  phase_q;
    logic [7:0]                  quiet_q;
    logic [cdt_pkg::HoldW-1:0]   held_q;
    logic [4:0]                  bar_q;
    logic                        buzz_q;

    cdt_pkg::t_res               due_outputs[$];
    int                          n_results;

    initial begin
        o_errors  = 0;
        o_waiting = 0;
        n_results = 0;
    end

    task automatic flag_mismatch(input string what);
        if (o_errors < MaxPrinted) begin
            $display("[%0t] result %0d: %s", $realtime, n_results, what);
        end
        o_errors++;
    endtask

    function automatic logic [4:0] segments_for(input logic [cdt_pkg::RemainW-1:0] cnt);
        int unsigned step;
        step = 5 * unit_cfg;
        if (cnt <= step) begin
            return 5'h01;
        end else if (cnt <= 2 * step) begin
            return 5'h03;
        end else if (cnt <= 3 * step) begin
            return 5'h07;
        end else if (cnt <= 4 * step) begin
            return 5'h0F;
        end
        return 5'h1F;
    endfunction

    task automatic advance_tick(input logic lvl);
        if (quiet_q != 8'd0) quiet_q--;
        if (awake_q) begin
            phase_q = (phase_q == cdt_pkg::PHASE_LAST) ? 6'd0 : phase_q + 6'd1;
            if (left_q != '0) begin
                buzz_q = 1'b0;
                if (phase_q <= cdt_pkg::LED_ON_LAST) begin
                    bar_q |= segments_for(left_q);
                end else begin
                    bar_q = 5'h00;
                end
                if (phase_q == 6'd0) left_q--;
            end else begin
                bar_q  = 5'h00;
                buzz_q = (phase_q <= cdt_pkg::BUZZ_ON_LAST);
            end
        end
        if (lvl) begin
            if (held_q != cdt_pkg::HOLD_MAX) held_q++;
            buzz_q = 1'b1;
            if (held_q == {1'b0, sleep_cfg}) begin
                awake_q = 1'b0;
                bar_q   = 5'h00;
                buzz_q  = 1'b0;
            end
        end else begin
            held_q = '0;
        end
    endtask

    task automatic take_press();
        logic [cdt_pkg::RemainW:0] sum;
        if (quiet_q != 8'd0) return;
        quiet_q = quiet_cfg;
        awake_q = 1'b1;
        buzz_q  = 1'b1;
        sum     = {1'b0, left_q} + (cdt_pkg::RemainW + 1)'(5 * unit_cfg);
        left_q  = sum[cdt_pkg::RemainW] ? '1 : sum[cdt_pkg::RemainW-1:0];
        bar_q  |= segments_for(left_q);
    endtask

    always @(posedge i_clk) begin : watch
        cdt_pkg::t_res want;
        if (!i_rst_n) begin
            unit_cfg  = cdt_pkg::HSPM_RESET;
            quiet_cfg = cdt_pkg::DEBOUNCE_RESET;
            sleep_cfg = cdt_pkg::LONG_PRESS_RESET;
            awake_q   = 1'b0;
            left_q    = cdt_pkg::REMAIN_RESET;
            phase_q   = '0;
            quiet_q   = '0;
            held_q    = '0;
            bar_q     = '0;
            buzz_q    = 1'b0;
            due_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cdt_pkg::CFG_HSPM: begin
                        unit_cfg = i_cfg_wdata;
                    end
                    cdt_pkg::CFG_DEBOUNCE: begin
                        quiet_cfg = i_cfg_wdata[7:0];
                    end
                    cdt_pkg::CFG_LONG_PRESS: begin
                        sleep_cfg = i_cfg_wdata[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.func) begin
                    take_press();
                end else begin
                    advance_tick(i_req.button_level);
                end
                want.leds   = bar_q;
                want.buzzer = buzz_q;
                want.active = awake_q;
                due_outputs.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                if (due_outputs.size() == 0) begin
                    flag_mismatch("result with no request waiting");
                end else begin
                    want = due_outputs.pop_front();
                    if (i_res.leds !== want.leds) begin
                        flag_mismatch($sformatf("leds %b, expected %b", i_res.leds, want.leds));
                    end
                    if (i_res.buzzer !== want.buzzer) begin
                        flag_mismatch($sformatf("buzzer %b, expected %b",
                                                i_res.buzzer, want.buzzer));
                    end
                    if (i_res.active !== want.active) begin
                        flag_mismatch($sformatf("active %b, expected %b",
                                                i_res.active, want.active));
                    end
                end
                n_results++;
            end
        end
        o_waiting <= due_outputs.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the countdown timer testbench: clock, reset, register writes and request
// stimulus with random idling; cdt_result_checker does the comparing.
// Depends on cdt_pkg, cdt_in_if, cdt_out_if, cdt_result_checker and the timer RTL.

module tb_top;

    localparam logic [1:0] CFG_SPARE    = 2'd3;
    localparam int         SettleCycles = 4;
    localparam int         HoldOffLen   = 90;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [9:0] cfg_wdata;

    int         src_idle;
    int         sink_stall;
    int         phase_no;
    logic       hold_off_go;
    logic [7:0] lp_now;
    int         waiting;
    int         errors;

    cdt_in_if  req_if();
    cdt_out_if res_if();

    countdown_timer_led_bar_buzzer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    cdt_result_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .o_waiting  (waiting),
        .o_errors   (errors)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #(12 * 300000);
        $display("countdown_timer_led_bar_buzzer test failed");
        $finish;
    end

    // The result side: random stalls, and one long hold-off when asked for.
    initial begin : sink_side
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go) begin
                res_if.ready <= 1'b0;
                repeat (HoldOffLen) @(posedge i_clk);
                hold_off_go = 1'b0;
            end
            res_if.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    task automatic send_event(input logic f, input logic lvl);
        if (src_idle != 0 && $urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.button_level <= lvl;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [9:0] hspm, input logic [7:0] deb,
                                 input logic [7:0] lp);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= cdt_pkg::CFG_HSPM;
        cfg_wdata <= hspm;
        @(posedge i_clk);
        cfg_idx   <= cdt_pkg::CFG_DEBOUNCE;
        cfg_wdata <= {2'($urandom), deb};
        @(posedge i_clk);
        cfg_idx   <= cdt_pkg::CFG_LONG_PRESS;
        cfg_wdata <= {2'($urandom), lp};
        @(posedge i_clk);
        cfg_idx   <= CFG_SPARE;
        cfg_wdata <= 10'($urandom);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        lp_now = lp;
        case (phase_no % 4)
            0: begin
                src_idle = 0;
                sink_stall = 0;
            end
            1: begin
                src_idle = 72;
                sink_stall = 0;
            end
            2: begin
                src_idle = 0;
                sink_stall = 72;
            end
            default: begin
                src_idle = 6;
                sink_stall = 6;
            end
        endcase
        phase_no++;
    endtask

    // Mostly well-formed use: tick runs, presses, holds around the sleep length.
    task automatic random_stream(input int n);
        int sent;
        int run;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                run = $urandom_range(1, 40);
                repeat (run) send_event(1'b0, 1'b0);
                sent += run;
            end else if (pick < 60) begin
                run = $urandom_range(1, 3);
                repeat (run) send_event(1'b1, 1'($urandom));
                sent += run;
            end else if (pick < 80) begin
                run = $urandom_range(1, int'(lp_now) + 2);
                if (run > 60) run = 60;
                repeat (run) send_event(1'b0, 1'b1);
                send_event(1'b0, 1'b0);
                sent += run + 1;
            end else begin
                run = $urandom_range(1, 5);
                repeat (run) send_event(1'($urandom), 1'($urandom));
                sent += run;
            end
        end
    endtask

    initial begin : stimulus
        int pick;
        req_if.valid        <= 1'b0;
        req_if.func         <= 1'b0;
        req_if.button_level <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= cdt_pkg::CFG_HSPM;
        cfg_wdata           <= '0;
        i_rst_n             <= 1'b0;
        hold_off_go = 1'b0;
        src_idle    = 0;
        sink_stall  = 0;
        phase_no    = 0;
        lp_now      = cdt_pkg::LONG_PRESS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero step, zero debounce and zero long press, then directed events.
        apply_setting(10'd0, 8'd0, 8'd0);
        send_event(1'b0, 1'b0);
        send_event(1'b0, 1'b1);
        send_event(1'b0, 1'b1);
        send_event(1'b0, 1'b0);
        send_event(1'b1, 1'b1);
        send_event(1'b1, 1'b0);
        repeat (12) send_event(1'b0, 1'b0);
        repeat (3) send_event(1'b0, 1'b1);
        send_event(1'b1, 1'b0);
        send_event(1'b0, 1'b0);

        // With a zero step the presses add nothing and the ticks walk the phases.
        apply_setting(10'd0, 8'd3, 8'd255);
        repeat (60) begin
            pick = $urandom_range(99);
            if (pick < 88) begin
                send_event(1'b0, 1'b0);
            end else if (pick < 94) begin
                send_event(1'b1, 1'($urandom));
            end else begin
                send_event(1'b0, 1'b1);
            end
        end

        apply_setting(10'd1, 8'd1, 8'd255);
        hold_off_go = 1'b1;
        random_stream(25);
        apply_setting(10'd1, 8'd0, 8'd3);
        random_stream(25);
        apply_setting(10'd3, 8'd20, 8'd12);
        random_stream(25);
        apply_setting(cdt_pkg::HSPM_RESET, cdt_pkg::DEBOUNCE_RESET, cdt_pkg::LONG_PRESS_RESET);
        random_stream(25);
        apply_setting(10'd1000, 8'd255, 8'd1);
        random_stream(25);
        apply_setting(10'($urandom_range(1, 1023)), 8'($urandom), 8'($urandom_range(1, 40)));
        random_stream(25);
        apply_setting(10'd7, 8'd1, 8'd40);
        random_stream(25);

        // A long hold must put the block to sleep once.
        apply_setting(10'd2, 8'd255, 8'd1);
        send_event(1'b1, 1'b0);
        repeat (30) send_event(1'b0, 1'b1);
        send_event(1'b0, 1'b0);

        // Largest step with every press accepted drives the count into saturation.
        apply_setting(10'd1023, 8'd0, 8'd255);
        repeat (210) send_event(1'b1, 1'($urandom));
        repeat (10) send_event(1'b0, 1'b0);

        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("countdown_timer_led_bar_buzzer test passed");
        end else begin
            $display("countdown_timer_led_bar_buzzer test failed");
        end
        $finish;
    end

endmodule
